// ===== design/sgop_pkg.sv =====
package sgop_pkg;

  localparam int TILE_ROWS = 4;
  localparam int TILE_COLS = 8;
  localparam int MAX_ROWS  = 4;
  localparam int MAX_COLS  = 8;
  localparam int LEN_W     = 13;
  localparam int STEP_W    = 12;
  localparam int ROW_W     = 2;
  localparam logic [LEN_W-1:0] MAX_K = 13'd4096;
  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  typedef struct packed {
    logic [31:0] a_row0;
    logic [31:0] a_row1;
    logic [31:0] a_row2;
    logic [31:0] a_row3;
    logic [31:0] b_col0;
    logic [31:0] b_col1;
    logic [31:0] b_col2;
    logic [31:0] b_col3;
    logic [31:0] b_col4;
    logic [31:0] b_col5;
    logic [31:0] b_col6;
    logic [31:0] b_col7;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  row_index;
    logic [31:0] sum_col0;
    logic [31:0] sum_col1;
    logic [31:0] sum_col2;
    logic [31:0] sum_col3;
    logic [31:0] sum_col4;
    logic [31:0] sum_col5;
    logic [31:0] sum_col6;
    logic [31:0] sum_col7;
    logic        last_row;
  } out_item_t;

  typedef struct packed {
    logic use_zero;
    logic acc_we;
  } lane_ctl_t;

  typedef logic [MAX_ROWS-1:0][MAX_COLS-1:0][31:0] tile_t;

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd48;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(47 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc28(input logic [27:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd28;
    found = 1'b0;
    for (int i = 27; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 5'(27 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [31:0] canon(input logic [31:0] f);
    if (f[30:23] == 8'hFF && f[22:0] != 23'd0) begin
      return CANON_NAN;
    end
    return f;
  endfunction

endpackage

// ===== design/sgop_lane.sv =====
module sgop_lane (
  input  logic               clk,
  input  logic [31:0]        a_i,
  input  logic [31:0]        b_i,
  input  sgop_pkg::lane_ctl_t ctl,
  output logic [31:0]        sum_o
);

  // multiply: stage 1
  logic        m1_nan_r, m1_inf_r, m1_zero_r, m1_sign_r;
  logic [47:0] m1_prod_r;
  logic [8:0]  m1_esum_r;
  logic        m1_nan_nxt, m1_inf_nxt, m1_zero_nxt, m1_sign_nxt;
  logic [47:0] m1_prod_nxt;
  logic [8:0]  m1_esum_nxt;

  always_comb begin
    logic [7:0] ea, eb;
    logic       za, zb, ia, ib, na, nb;
    ea = a_i[30:23];
    eb = b_i[30:23];
    za = a_i[30:0] == 31'd0;
    zb = b_i[30:0] == 31'd0;
    ia = ea == 8'hFF && a_i[22:0] == 23'd0;
    ib = eb == 8'hFF && b_i[22:0] == 23'd0;
    na = ea == 8'hFF && a_i[22:0] != 23'd0;
    nb = eb == 8'hFF && b_i[22:0] != 23'd0;
    m1_nan_nxt  = na | nb | (ia & zb) | (ib & za);
    m1_inf_nxt  = ia | ib;
    m1_zero_nxt = za | zb;
    m1_sign_nxt = a_i[31] ^ b_i[31];
    m1_prod_nxt = {24'd0, (ea != 8'd0), a_i[22:0]} * {24'd0, (eb != 8'd0), b_i[22:0]};
    m1_esum_nxt = {1'b0, (ea != 8'd0) ? ea : 8'd1} + {1'b0, (eb != 8'd0) ? eb : 8'd1};
  end

  // multiply: stage 2, leading zero count
  logic        m2_nan_r, m2_inf_r, m2_zero_r, m2_sign_r;
  logic [47:0] m2_prod_r;
  logic [8:0]  m2_esum_r;
  logic [5:0]  m2_lz_r;
  logic [10:0] m2_x_r;
  logic [5:0]  m2_lz_nxt;
  logic [10:0] m2_x_nxt;

  always_comb begin
    m2_lz_nxt = sgop_pkg::lzc48(m1_prod_r);
    m2_x_nxt  = 11'(m1_esum_r) - 11'd126 - 11'(m2_lz_nxt);
  end

  // multiply: stage 3, normalize and round
  logic [31:0] p_r;
  logic [31:0] p_nxt;

  always_comb begin
    logic [47:0] n;
    logic        lost, normal, ovf, rnd;
    logic [6:0]  r;
    logic [7:0]  fld;
    logic [30:0] body;
    normal = !m2_x_r[10] && m2_x_r != 11'd0;
    ovf    = normal && m2_x_r >= 11'd255;
    lost   = 1'b0;
    r      = 7'd0;
    fld    = 8'd0;
    if (normal) begin
      n   = m2_prod_r << m2_lz_r;
      fld = m2_x_r[7:0];
    end else if (m2_esum_r >= 9'd127) begin
      n = m2_prod_r << (m2_esum_r - 9'd127);
    end else begin
      r = 7'(9'd127 - m2_esum_r);
      if (r >= 7'd48) begin
        n    = 48'd0;
        lost = |m2_prod_r;
      end else begin
        n    = m2_prod_r >> r;
        lost = |(m2_prod_r & ((48'd1 << r) - 48'd1));
      end
    end
    rnd  = n[23] & ((|n[22:0]) | lost | n[24]);
    body = {fld, n[46:24]} + 31'(rnd);
    priority if (m2_nan_r) begin
      p_nxt = sgop_pkg::CANON_NAN;
    end else if (m2_inf_r || ovf) begin
      p_nxt = {m2_sign_r, 8'hFF, 23'd0};
    end else if (m2_zero_r) begin
      p_nxt = {m2_sign_r, 31'd0};
    end else begin
      p_nxt = {m2_sign_r, body};
    end
  end

  // add: stage 1, order and align
  logic [31:0] acc_r;
  logic [31:0] acc_nxt;
  logic        a1_nan_r, a1_inf_r, a1_infs_r, a1_sub_r, a1_sign_r;
  logic [7:0]  a1_eb_r;
  logic [26:0] a1_bigm_r, a1_al_r;
  logic        a1_nan_nxt, a1_inf_nxt, a1_infs_nxt, a1_sub_nxt, a1_sign_nxt;
  logic [7:0]  a1_eb_nxt;
  logic [26:0] a1_bigm_nxt, a1_al_nxt;

  always_comb begin
    logic [31:0] x, y, bg, sm;
    logic        ix, iy, nx, ny;
    logic [7:0]  es, d;
    logic [26:0] smm;
    x  = ctl.use_zero ? 32'd0 : acc_r;
    y  = p_r;
    ix = x[30:23] == 8'hFF && x[22:0] == 23'd0;
    iy = y[30:23] == 8'hFF && y[22:0] == 23'd0;
    nx = x[30:23] == 8'hFF && x[22:0] != 23'd0;
    ny = y[30:23] == 8'hFF && y[22:0] != 23'd0;
    a1_nan_nxt  = nx | ny | (ix & iy & (x[31] != y[31]));
    a1_inf_nxt  = ix | iy;
    a1_infs_nxt = ix ? x[31] : y[31];
    if (y[30:0] > x[30:0]) begin
      bg = y;
      sm = x;
    end else begin
      bg = x;
      sm = y;
    end
    a1_sub_nxt  = x[31] ^ y[31];
    a1_sign_nxt = bg[31];
    a1_eb_nxt   = (bg[30:23] != 8'd0) ? bg[30:23] : 8'd1;
    es          = (sm[30:23] != 8'd0) ? sm[30:23] : 8'd1;
    d           = a1_eb_nxt - es;
    a1_bigm_nxt = {(bg[30:23] != 8'd0), bg[22:0], 3'b000};
    smm         = {(sm[30:23] != 8'd0), sm[22:0], 3'b000};
    if (d >= 8'd27) begin
      a1_al_nxt = {26'd0, smm != 27'd0};
    end else begin
      a1_al_nxt = (smm >> d) | 27'(|(smm & ((27'd1 << d) - 27'd1)));
    end
  end

  // add: stage 2, add and count
  logic        a2_nan_r, a2_inf_r, a2_infs_r, a2_sub_r, a2_sign_r;
  logic [7:0]  a2_eb_r;
  logic [27:0] a2_sum_r;
  logic [4:0]  a2_lz_r;
  logic [27:0] a2_sum_nxt;

  always_comb begin
    if (a1_sub_r) begin
      a2_sum_nxt = {1'b0, a1_bigm_r} - {1'b0, a1_al_r};
    end else begin
      a2_sum_nxt = {1'b0, a1_bigm_r} + {1'b0, a1_al_r};
    end
  end

  // add: stage 3, normalize and round
  always_comb begin
    logic [7:0]  sh;
    logic [8:0]  xe;
    logic [27:0] n;
    logic [7:0]  fld;
    logic        ovf, rnd;
    logic [30:0] body;
    sh   = ({3'd0, a2_lz_r} <= a2_eb_r) ? {3'd0, a2_lz_r} : a2_eb_r;
    xe   = {1'b0, a2_eb_r} + 9'd1 - {1'b0, sh};
    n    = a2_sum_r << sh;
    fld  = n[27] ? xe[7:0] : 8'd0;
    ovf  = n[27] && xe >= 9'd255;
    rnd  = n[3] & ((|n[2:0]) | n[4]);
    body = {fld, n[26:4]} + 31'(rnd);
    priority if (a2_nan_r) begin
      acc_nxt = sgop_pkg::CANON_NAN;
    end else if (a2_inf_r) begin
      acc_nxt = {a2_infs_r, 8'hFF, 23'd0};
    end else if (a2_sum_r == 28'd0) begin
      acc_nxt = {a2_sign_r & !a2_sub_r, 31'd0};
    end else if (ovf) begin
      acc_nxt = {a2_sign_r, 8'hFF, 23'd0};
    end else begin
      acc_nxt = {a2_sign_r, body};
    end
  end

  assign sum_o = acc_nxt;

  always_ff @(posedge clk) begin
    m1_nan_r  <= m1_nan_nxt;
    m1_inf_r  <= m1_inf_nxt;
    m1_zero_r <= m1_zero_nxt;
    m1_sign_r <= m1_sign_nxt;
    m1_prod_r <= m1_prod_nxt;
    m1_esum_r <= m1_esum_nxt;
    m2_nan_r  <= m1_nan_r;
    m2_inf_r  <= m1_inf_r;
    m2_zero_r <= m1_zero_r;
    m2_sign_r <= m1_sign_r;
    m2_prod_r <= m1_prod_r;
    m2_esum_r <= m1_esum_r;
    m2_lz_r   <= m2_lz_nxt;
    m2_x_r    <= m2_x_nxt;
    p_r       <= p_nxt;
    a1_nan_r  <= a1_nan_nxt;
    a1_inf_r  <= a1_inf_nxt;
    a1_infs_r <= a1_infs_nxt;
    a1_sub_r  <= a1_sub_nxt;
    a1_sign_r <= a1_sign_nxt;
    a1_eb_r   <= a1_eb_nxt;
    a1_bigm_r <= a1_bigm_nxt;
    a1_al_r   <= a1_al_nxt;
    a2_nan_r  <= a1_nan_r;
    a2_inf_r  <= a1_inf_r;
    a2_infs_r <= a1_infs_r;
    a2_sub_r  <= a1_sub_r;
    a2_sign_r <= a1_sign_r;
    a2_eb_r   <= a1_eb_r;
    a2_sum_r  <= a2_sum_nxt;
    a2_lz_r   <= sgop_pkg::lzc28(a2_sum_nxt);
    if (ctl.acc_we) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

// ===== design/sgop_merge.sv =====
module sgop_merge #(
  parameter int TILE_ROWS = sgop_pkg::TILE_ROWS,
  parameter int TILE_COLS = sgop_pkg::TILE_COLS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  sgop_pkg::tile_t     wr_tile,
  output logic                out_valid,
  input  logic                out_ready,
  output sgop_pkg::out_item_t out_data,
  output logic                pend_full
);

  localparam logic [sgop_pkg::ROW_W-1:0] LAST_ROW = sgop_pkg::ROW_W'(TILE_ROWS - 1);

  sgop_pkg::tile_t                 buf_r, buf_nxt;
  sgop_pkg::tile_t                 pend_r, pend_nxt;
  logic                            busy_r, busy_nxt;
  logic                            pend_v_r, pend_v_nxt;
  logic                            free;
  logic [sgop_pkg::ROW_W-1:0]      ptr_r, ptr_nxt;
  logic [sgop_pkg::MAX_COLS-1:0][31:0] col;

  always_comb begin
    busy_nxt   = busy_r;
    ptr_nxt    = ptr_r;
    buf_nxt    = buf_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    free       = !busy_r || (out_ready && ptr_r == LAST_ROW);
    if (busy_r && out_ready && ptr_r != LAST_ROW) begin
      ptr_nxt = ptr_r + 1'b1;
    end
    if (free) begin
      busy_nxt = pend_v_r || wr_en;
      ptr_nxt  = '0;
      if (pend_v_r) begin
        buf_nxt    = pend_r;
        pend_v_nxt = wr_en;
        if (wr_en) begin
          pend_nxt = wr_tile;
        end
      end else if (wr_en) begin
        buf_nxt = wr_tile;
      end
    end else if (wr_en) begin
      pend_nxt   = wr_tile;
      pend_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      pend_v_r <= 1'b0;
      ptr_r    <= '0;
    end else begin
      busy_r   <= busy_nxt;
      pend_v_r <= pend_v_nxt;
      ptr_r    <= ptr_nxt;
    end
    buf_r  <= buf_nxt;
    pend_r <= pend_nxt;
  end

  always_comb begin
    for (int c = 0; c < sgop_pkg::MAX_COLS; c++) begin
      col[c] = (c < TILE_COLS) ? sgop_pkg::canon(buf_r[ptr_r][c]) : 32'd0;
    end
  end

  assign pend_full = pend_v_r;
  assign out_valid = busy_r;
  assign out_data  = '{
    row_index: ptr_r,
    sum_col0:  col[0],
    sum_col1:  col[1],
    sum_col2:  col[2],
    sum_col3:  col[3],
    sum_col4:  col[4],
    sum_col5:  col[5],
    sum_col6:  col[6],
    sum_col7:  col[7],
    last_row:  ptr_r == LAST_ROW
  };

endmodule

// ===== design/sgemm_tile_outer_product.sv =====
// An accepted item passes the lane multiply and add stages before updating the accumulators;
// the first row of a finished tile is valid once the tile is registered into the output buffer
// when the output is idle. Items are spaced by the 3-stage float add loop on each accumulator:
// none is accepted while an earlier one is in multiply stage 1 or 2; a tile's last item waits
// while another tile end is in flight or a finished tile is queued behind the one being emitted.
// Reset (rst_n, synchronous): clears step count, valids and output queue; k_length = 1.
module sgemm_tile_outer_product #(
  parameter int TILE_ROWS = sgop_pkg::TILE_ROWS,
  parameter int TILE_COLS = sgop_pkg::TILE_COLS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  sgop_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output sgop_pkg::out_item_t          out_data,
  input  logic                         cfg_we,
  input  logic [sgop_pkg::LEN_W-1:0]   cfg_data
);

  logic [sgop_pkg::LEN_W-1:0]  len_r, eff_len;
  logic [sgop_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [4:0]                  v_r, v_nxt, first_r, first_nxt, last_r, last_nxt;
  logic                        is_last, last_inflight, accept, tile_wr, pend_full;
  logic [sgop_pkg::MAX_ROWS-1:0][31:0] a_arr;
  logic [sgop_pkg::MAX_COLS-1:0][31:0] b_arr;
  sgop_pkg::tile_t             sums;
  sgop_pkg::lane_ctl_t         ctl;

  always_comb begin
    priority if (len_r == '0) begin
      eff_len = sgop_pkg::LEN_W'(1);
    end else if (len_r > sgop_pkg::MAX_K) begin
      eff_len = sgop_pkg::MAX_K;
    end else begin
      eff_len = len_r;
    end
  end

  assign is_last       = ({1'b0, step_r} + 1'b1) >= eff_len;
  assign last_inflight = |(v_r & last_r);
  assign in_ready      = !v_r[0] && !v_r[1] && (!is_last || (!pend_full && !last_inflight));
  assign accept        = in_valid && in_ready;
  assign tile_wr       = v_r[4] && last_r[4];

  always_comb begin
    step_nxt = step_r;
    if (accept) begin
      step_nxt = is_last ? '0 : step_r + 1'b1;
    end
    v_nxt     = {v_r[3:0], accept};
    first_nxt = {first_r[3:0], step_r == '0};
    last_nxt  = {last_r[3:0], is_last};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= sgop_pkg::LEN_W'(1);
      step_r <= '0;
      v_r    <= '0;
    end else begin
      if (cfg_we) begin
        len_r <= cfg_data;
      end
      step_r <= step_nxt;
      v_r    <= v_nxt;
    end
    first_r <= first_nxt;
    last_r  <= last_nxt;
  end

  assign a_arr = {in_data.a_row3, in_data.a_row2, in_data.a_row1, in_data.a_row0};
  assign b_arr = {in_data.b_col7, in_data.b_col6, in_data.b_col5, in_data.b_col4,
                  in_data.b_col3, in_data.b_col2, in_data.b_col1, in_data.b_col0};
  assign ctl   = '{use_zero: first_r[2], acc_we: v_r[4]};

  for (genvar r = 0; r < sgop_pkg::MAX_ROWS; r++) begin : g_row
    for (genvar c = 0; c < sgop_pkg::MAX_COLS; c++) begin : g_col
      if (r < TILE_ROWS && c < TILE_COLS) begin : g_lane
        sgop_lane u_lane (
          .clk   (clk),
          .a_i   (a_arr[r]),
          .b_i   (b_arr[c]),
          .ctl   (ctl),
          .sum_o (sums[r][c])
        );
      end else begin : g_idle
        assign sums[r][c] = 32'd0;
      end
    end
  end

  sgop_merge #(
    .TILE_ROWS (TILE_ROWS),
    .TILE_COLS (TILE_COLS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (tile_wr),
    .wr_tile   (sums),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .pend_full (pend_full)
  );

  a_wr_free: assert property (@(posedge clk) disable iff (!rst_n)
    tile_wr |-> !pend_full) else $error("tile written while output queue full");
  a_one_last: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(v_r & last_r)) else $error("two tile ends in flight");
  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready) else $error("items closer than the add loop");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("output row changed while stalled");

endmodule
